### rtl/core/kosf_pkg.sv
// ----------------------------------------------------------------------------
// kosf_pkg
// Shared types, constants and register codes for the octagon/square fold core.
// ----------------------------------------------------------------------------
package kosf_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int FOLD_STEPS = 32;
  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);

  localparam logic [29:0] SIN_Q30 =
    30'((64'd38268 * 64'd1073741824 + 64'd50000) / 64'd100000);
  localparam logic [29:0] COS_Q30 =
    30'((64'd92388 * 64'd1073741824 + 64'd50000) / 64'd100000);
  localparam logic [29:0] TAN_Q30 =
    30'((64'd38268 * 64'd1073741824 + 64'd46194) / 64'd92388);
  localparam logic [63:0] HALF_Q30 = 64'd536870912;

  localparam logic [31:0] INVALID_COORD = 32'(64'd0 - (64'd1000 << FRAC_BITS));

  // configuration register indexes
  localparam logic [7:0] REG_CELL_SIZE    = 8'd0;
  localparam logic [7:0] REG_FRESH_OUTPUT = 8'd1;

  typedef struct packed {
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic               parity_in;
    logic               invalid_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic               parity_out;
    logic               invalid_out;
  } out_item_t;

  typedef struct packed {
    logic [30:0] size;   // never zero
    logic [31:0] w2;     // twice the size
    logic [31:0] t;      // size * (1 + tan 22.5)
    logic        fresh;
  } cfg_t;

  // classified item, as queued between front and back
  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic        par;
    logic        inval;
    logic [31:0] xr;
    logic [31:0] yr;
  } cls_t;

endpackage

### rtl/core/kosf_cfg.sv
// ----------------------------------------------------------------------------
// kosf_cfg
// Configuration registers and the derived fold limits.
// ----------------------------------------------------------------------------
module kosf_cfg import kosf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  logic [30:0] cell_size;
  logic        fresh_output;
  logic [30:0] size_eff;
  logic [60:0] tprod;
  logic [31:0] t;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size    <= 31'd65536;
      fresh_output <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == REG_CELL_SIZE) begin
        cell_size <= cfg_data[30:0];
      end
      if (cfg_index == REG_FRESH_OUTPUT) begin
        fresh_output <= cfg_data[0];
      end
    end
  end

  // a zero size acts as one LSB
  assign size_eff = (cell_size == 31'd0) ? 31'd1 : cell_size;
  assign tprod    = 61'(size_eff) * 61'(TAN_Q30);

  always_ff @(posedge clk) begin
    t <= 32'(size_eff) + 32'((64'(tprod) + HALF_Q30) >> 30);
  end

  assign cfg.size  = size_eff;
  assign cfg.w2    = {size_eff, 1'b0};
  assign cfg.t     = t;
  assign cfg.fresh = fresh_output;

endmodule

### rtl/core/kosf_front.sv
// ----------------------------------------------------------------------------
// kosf_front
// Input stage: takes items, splits off sign and magnitude, sets up parity.
// ----------------------------------------------------------------------------
module kosf_front import kosf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output cls_t     q_item
);

  logic fv;
  cls_t item;
  logic acc;

  assign in_ready = !fv || !q_full;
  assign acc      = in_valid && in_ready;
  assign q_push   = fv && !q_full;
  assign q_item   = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (acc) begin
      fv <= 1'b1;
    end else if (q_push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      item.inval <= in_data.invalid_in;
      item.xr    <= in_data.x_in;
      item.yr    <= in_data.y_in;
      // invalid items keep their parity untouched; zero magnitudes keep
      // every fold stage from toggling it
      if (in_data.invalid_in) begin
        item.ax  <= '0;
        item.ay  <= '0;
        item.par <= in_data.parity_in;
      end else begin
        item.ax  <= in_data.x_in[31] ? 32'(-in_data.x_in) : 32'(in_data.x_in);
        item.ay  <= in_data.y_in[31] ? 32'(-in_data.y_in) : 32'(in_data.y_in);
        item.par <= in_data.parity_in ^ in_data.x_in[31] ^ in_data.y_in[31];
      end
    end
  end

endmodule

### rtl/core/kosf_queue.sv
// ----------------------------------------------------------------------------
// kosf_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module kosf_queue import kosf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cls_t push_item,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output cls_t head
);

  cls_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full     = (count == (QAW+1)'(QDEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !push) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty) else $error("queue pop while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("queue count slip");

endmodule

### rtl/core/kosf_back.sv
// ----------------------------------------------------------------------------
// kosf_back
// Fold pipeline: bit-serial remainder stages, mirror, swap and reflect,
// then the 22.5 degree reflection through two registered multiplies.
// ----------------------------------------------------------------------------
module kosf_back import kosf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_nonempty,
  input  cls_t      q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] rx;
    logic [31:0] ry;
    logic        par;
    logic        inval;
    logic [31:0] xr;
    logic [31:0] yr;
  } rem_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic        par;
    logic        inval;
    logic [31:0] xr;
    logic [31:0] yr;
  } pt_t;

  typedef struct packed {
    pt_t         p;
    logic [61:0] px;
    logic [61:0] py;
  } mul_t;

  typedef struct packed {
    pt_t         p;
    logic [33:0] d;
    logic        pos;
  } dif_t;

  typedef struct packed {
    pt_t         p;
    logic [64:0] mx;
    logic [64:0] my;
    logic        pos;
  } prd_t;

  logic en;
  rem_t rem     [FOLD_STEPS+1];
  logic rem_v   [FOLD_STEPS+1];
  rem_t rem_nxt [FOLD_STEPS+1];
  pt_t  mir, refl, mir_next, refl_next;
  logic mir_v, refl_v, mul_v, dif_v, prd_v;
  mul_t mul;
  dif_t dif;
  prd_t prd;
  logic signed [63:0] dq;
  logic [63:0] dr;
  logic [34:0] dx, dy;
  logic signed [37:0] xs, ys;
  out_item_t res;

  assign en    = !out_valid || out_ready;
  assign q_pop = en && q_nonempty;

  // one quotient bit per stage: shift in, compare and subtract
  always_comb begin
    logic [32:0] sx;
    logic [32:0] sy;
    rem_nxt[0] = rem[0];
    for (int k = 0; k < FOLD_STEPS; k++) begin
      sx = {rem[k].rx, rem[k].ax[FOLD_STEPS-1-k]};
      sy = {rem[k].ry, rem[k].ay[FOLD_STEPS-1-k]};
      rem_nxt[k+1] = rem[k];
      rem_nxt[k+1].rx = (sx >= {1'b0, cfg.w2}) ? 32'(sx - {1'b0, cfg.w2}) : sx[31:0];
      rem_nxt[k+1].ry = (sy >= {1'b0, cfg.w2}) ? 32'(sy - {1'b0, cfg.w2}) : sy[31:0];
    end
  end

  // mirror the upper half of the doubled cell
  always_comb begin
    mir_next.par   = rem[FOLD_STEPS].par;
    mir_next.inval = rem[FOLD_STEPS].inval;
    mir_next.xr    = rem[FOLD_STEPS].xr;
    mir_next.yr    = rem[FOLD_STEPS].yr;
    mir_next.x     = rem[FOLD_STEPS].rx;
    mir_next.y     = rem[FOLD_STEPS].ry;
    if (rem[FOLD_STEPS].rx > 32'(cfg.size)) begin
      mir_next.x   = cfg.w2 - rem[FOLD_STEPS].rx;
      mir_next.par = !mir_next.par;
    end
    if (rem[FOLD_STEPS].ry > 32'(cfg.size)) begin
      mir_next.y   = cfg.w2 - rem[FOLD_STEPS].ry;
      mir_next.par = !mir_next.par;
    end
  end

  // swap across x=y, then reflect across x+y=t
  always_comb begin
    pt_t s;
    s = mir;
    if (mir.y > mir.x) begin
      s.x   = mir.y;
      s.y   = mir.x;
      s.par = !mir.par;
    end
    refl_next = s;
    if (({1'b0, s.x} + {1'b0, s.y}) > {1'b0, cfg.t}) begin
      refl_next.x   = cfg.t - s.y;
      refl_next.y   = cfg.t - s.x;
      refl_next.par = !s.par;
    end
  end

  assign dq = $signed({2'b00, mul.py}) - $signed({2'b00, mul.px});
  assign dr = 64'(dq) + HALF_Q30;
  assign dx = 35'((65'(prd.mx) + 65'(HALF_Q30)) >> 30);
  assign dy = 35'((65'(prd.my) + 65'(HALF_Q30)) >> 30);
  assign xs = $signed({6'd0, prd.p.x}) + (prd.pos ? $signed({3'd0, dx}) : 38'sd0);
  assign ys = $signed({6'd0, prd.p.y}) - (prd.pos ? $signed({3'd0, dy}) : 38'sd0);

  always_comb begin
    res.invalid_out = prd.p.inval;
    if (prd.p.inval) begin
      if (cfg.fresh) begin
        res.x_out      = INVALID_COORD;
        res.y_out      = INVALID_COORD;
        res.parity_out = 1'b0;
      end else begin
        res.x_out      = prd.p.xr;
        res.y_out      = prd.p.yr;
        res.parity_out = prd.p.par;
      end
    end else begin
      res.parity_out = prd.p.par ^ prd.pos;
      priority if (xs > 38'sd2147483647) res.x_out = 32'h7fff_ffff;
      else if (xs < -38'sd2147483648)    res.x_out = 32'h8000_0000;
      else                               res.x_out = xs[31:0];
      priority if (ys > 38'sd2147483647) res.y_out = 32'h7fff_ffff;
      else if (ys < -38'sd2147483648)    res.y_out = 32'h8000_0000;
      else                               res.y_out = ys[31:0];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= FOLD_STEPS; k++) rem_v[k] <= 1'b0;
      mir_v     <= 1'b0;
      refl_v    <= 1'b0;
      mul_v     <= 1'b0;
      dif_v     <= 1'b0;
      prd_v     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      rem_v[0] <= q_pop;
      for (int k = 0; k < FOLD_STEPS; k++) rem_v[k+1] <= rem_v[k];
      mir_v     <= rem_v[FOLD_STEPS];
      refl_v    <= mir_v;
      mul_v     <= refl_v;
      dif_v     <= mul_v;
      prd_v     <= dif_v;
      out_valid <= prd_v;
    end
  end

  // payload: advance the whole line together
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0].ax    <= q_head.ax;
      rem[0].ay    <= q_head.ay;
      rem[0].rx    <= '0;
      rem[0].ry    <= '0;
      rem[0].par   <= q_head.par;
      rem[0].inval <= q_head.inval;
      rem[0].xr    <= q_head.xr;
      rem[0].yr    <= q_head.yr;
      for (int k = 1; k <= FOLD_STEPS; k++) rem[k] <= rem_nxt[k];
      mir      <= mir_next;
      refl     <= refl_next;
      mul.p    <= refl;
      mul.py   <= 62'(refl.y) * 62'(COS_Q30);
      mul.px   <= 62'(refl.x) * 62'(SIN_Q30);
      dif.p    <= mul.p;
      dif.pos  <= !dq[63] && (dq != 64'sd0);
      dif.d    <= dr[63:30];
      prd.p    <= dif.p;
      prd.pos  <= dif.pos;
      prd.mx   <= 65'({dif.d, 1'b0}) * 65'(SIN_Q30);
      prd.my   <= 65'({dif.d, 1'b0}) * 65'(COS_Q30);
      out_data <= res;
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    rem_v[FOLD_STEPS] && !rem[FOLD_STEPS].inval |->
      rem[FOLD_STEPS].rx < cfg.w2 && rem[FOLD_STEPS].ry < cfg.w2)
    else $error("fold remainder not below twice the size");
  a_mirror_bound: assert property (@(posedge clk) disable iff (rst)
    mir_v && !mir.inval |-> mir.x <= 32'(cfg.size) && mir.y <= 32'(cfg.size))
    else $error("mirrored point outside the cell");
  a_wedge: assert property (@(posedge clk) disable iff (rst)
    refl_v && !refl.inval |->
      refl.x >= refl.y && ({1'b0, refl.x} + {1'b0, refl.y}) <= {1'b0, cfg.t})
    else $error("point outside the wedge after reflection");

endmodule

### rtl/core/kaleidoscope_octagon_square_fold_core.sv
// ----------------------------------------------------------------------------
// kaleidoscope_octagon_square_fold_core
// Folds map coordinates into the fundamental cell of a *442 kaleidoscope.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid/in_ready     in_data   (in_item_t)
//  out      out_valid/out_ready   out_data  (out_item_t)
//  cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
//
//  One item per clock sustained while the output does not stall; between the
//  input handshake and out_valid lie the front register, the queue write,
//  the remainder load, 32 remainder stages and 6 fold/reflect/output stages.
//  The 32-stage bit-serial remainder sets the depth.
//  Synchronous reset clears valids and queue; cell_size = 1.0, fresh on.
//  A stalled output holds the back pipeline; the 4-entry queue absorbs
//  the front until it fills, then in_ready drops.
module kaleidoscope_octagon_square_fold_core import kosf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t cfg;
  logic q_full, q_push, q_pop, q_nonempty;
  cls_t q_item, q_head;

  kosf_cfg u_cfg (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg
  );

  kosf_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data, .q_full, .q_push, .q_item
  );

  kosf_queue u_queue (
    .clk, .rst, .push(q_push), .push_item(q_item), .full(q_full),
    .pop(q_pop), .nonempty(q_nonempty), .head(q_head)
  );

  kosf_back u_back (
    .clk, .rst, .cfg, .q_nonempty, .q_head, .q_pop,
    .out_valid, .out_ready, .out_data
  );

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams map coordinates through the octagon/square fold core under random
// idling on both channels and checks every folded item against a predictor.
// ----------------------------------------------------------------------------

class fold_scoreboard;
  kosf_pkg::out_item_t folded_q[$];
  int unsigned         mismatches;
  int unsigned         orphans;

  function void note_pixel(kosf_pkg::out_item_t exp_item);
    folded_q.push_back(exp_item);
  endfunction

  function void check_pixel(kosf_pkg::out_item_t got);
    kosf_pkg::out_item_t want;
    if (folded_q.size() == 0) begin
      orphans++;
      $display("unexpected item x=%h y=%h", got.x_out, got.y_out);
      return;
    end
    want = folded_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp x=%h y=%h p=%b i=%b  got x=%h y=%h p=%b i=%b",
                 want.x_out, want.y_out, want.parity_out, want.invalid_out,
                 got.x_out, got.y_out, got.parity_out, got.invalid_out);
    end
  endfunction
endclass

module tb_top;
  import kosf_pkg::*;

  localparam longint unsigned SIN_K = (64'd38268 * 64'd1073741824 + 64'd50000) / 64'd100000;
  localparam longint unsigned COS_K = (64'd92388 * 64'd1073741824 + 64'd50000) / 64'd100000;
  localparam longint unsigned TAN_K = (64'd38268 * 64'd1073741824 + 64'd46194) / 64'd92388;
  localparam longint unsigned HALF_K = 64'd536870912;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic [30:0] cell_size_q = 31'd65536;
  logic        fresh_q = 1'b1;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  fold_scoreboard sb;

  kaleidoscope_octagon_square_fold_core uut (.*);

  always #4 clk = ~clk;

  function automatic longint unsigned fold_axis(longint v, longint unsigned size,
                                                inout bit par);
    longint unsigned a;
    longint unsigned w2;
    w2 = 2 * size;
    if (v < 0) begin
      a = longint'(-v);
      par ^= 1'b1;
    end else begin
      a = v;
    end
    a = a % w2;
    if (a > size) begin
      a = w2 - a;
      par ^= 1'b1;
    end
    return a;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic out_item_t fold_pixel(in_item_t px);
    out_item_t r;
    longint unsigned size, t, x, y, h, d, dx, dy;
    longint dq, xs, ys;
    bit par;
    par = px.parity_in;
    r.invalid_out = px.invalid_in;
    if (px.invalid_in) begin
      if (fresh_q) begin
        r.x_out = INVALID_COORD;
        r.y_out = INVALID_COORD;
        r.parity_out = 1'b0;
      end else begin
        r.x_out = px.x_in;
        r.y_out = px.y_in;
        r.parity_out = px.parity_in;
      end
      return r;
    end
    size = (cell_size_q == 0) ? 64'd1 : longint'(cell_size_q);
    t = size + ((size * TAN_K + HALF_K) >> 30);
    x = fold_axis(longint'(px.x_in), size, par);
    y = fold_axis(longint'(px.y_in), size, par);
    if (y > x) begin
      h = x; x = y; y = h; par ^= 1'b1;
    end
    if (x + y > t) begin
      h = x; x = t - y; y = t - h; par ^= 1'b1;
    end
    xs = x;
    ys = y;
    dq = longint'(y * COS_K) - longint'(x * SIN_K);
    if (dq > 0) begin
      d = (longint'(dq) + HALF_K) >> 30;
      dx = (2 * d * SIN_K + HALF_K) >> 30;
      dy = (2 * d * COS_K + HALF_K) >> 30;
      xs += longint'(dx);
      ys -= longint'(dy);
      par ^= 1'b1;
    end
    r.x_out = clamp32(xs);
    r.y_out = clamp32(ys);
    r.parity_out = par;
    return r;
  endfunction

  // receiver: stall at random, check every accepted item
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_pixel(out_data);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // valid stays high between back-to-back items; drop it only to idle
  task automatic send_pixel(in_item_t px);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(fold_pixel(px));
  endtask

  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (sb.folded_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_CELL_SIZE) cell_size_q = val[30:0];
    else if (idx == REG_FRESH_OUTPUT) fresh_q = val[0];
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return $urandom_range(8) << 16;
      3: return -($urandom_range(8) << 16);
      4: return $urandom & 32'h0007ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_pixels(int n);
    in_item_t px;
    for (int i = 0; i < n; i++) begin
      px.x_in = pick_coord();
      px.y_in = pick_coord();
      px.parity_in = 1'($urandom_range(1));
      px.invalid_in = ($urandom_range(9) == 0);
      send_pixel(px);
    end
  endtask

  initial begin
    in_item_t px;
    logic [31:0] sizes[6];
    sb = new();
    sizes = '{32'd65536, 32'd0, 32'd1, 32'h7fffffff, 32'd200000, 32'h40000000};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, both modes, invalid pixels
    send_idle_pct = 37; recv_idle_pct = 86;
    foreach (sizes[s]) begin
      if (s < 3) begin
        write_reg(REG_CELL_SIZE, sizes[s]);
        write_reg(REG_FRESH_OUTPUT, 32'(s[0]));
        for (int k = 0; k < 6; k++) begin
          px.x_in = (k[0]) ? 32'h80000000 : 32'h7fffffff;
          px.y_in = (k[1]) ? 32'h80000000 : 32'h0000c000;
          px.parity_in = k[0];
          px.invalid_in = (k >= 4);
          send_pixel(px);
        end
        drain_pixels();
      end
    end

    // random phases across cell sizes and idling profiles
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle_pct = 86; recv_idle_pct = 37; end
      if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_reg(REG_CELL_SIZE, sizes[ph]);
      write_reg(REG_FRESH_OUTPUT, 32'(ph[0]));
      random_pixels(64);
      drain_pixels();
    end

    if (sb.mismatches == 0 && sb.orphans == 0 && sb.folded_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule

### kaleidoscope_octagon_square_fold_core.f
rtl/core/kosf_pkg.sv
rtl/core/kosf_cfg.sv
rtl/core/kosf_front.sv
rtl/core/kosf_queue.sv
rtl/core/kosf_back.sv
rtl/core/kaleidoscope_octagon_square_fold_core.sv
test/tb_top.sv
